// File: rtl/bbc_pkg.sv
// Shared types and constants for the LRU buffer cache core.
// Holds the entry word layout, request and status codes and table sizing.
// No dependencies.
package bbc_pkg;

  // Table sizing
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths fixed by the interface
  localparam int FUNC_W  = 2;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int EIDX_W  = 5;
  localparam int TICK_W  = 32;
  localparam int CNT_W   = 8;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Request codes
  localparam logic [FUNC_W-1:0] FN_GET     = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PIN     = 2'd2;
  localparam logic [FUNC_W-1:0] FN_UNPIN   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_COUNT  = 2'd2;

  // One buffer entry as stored in the table memory
  typedef struct packed {
    logic              tag_valid;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block;
    logic [CNT_W-1:0]  ref_count;
    logic [TICK_W-1:0] last_use;
    logic              data_valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/bbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/block_buffer_cache_lru_core.sv
// LRU buffer cache tag and reference-count core; top level.
// Depends on bbc_pkg and bbc_ram.
//
// The entry table lives in one synchronous RAM of ENTRIES words; a row of
// per-entry valid flops makes every entry read as all zero until it is first
// written, so no clearing pass follows reset. One request is worked at a time.
// A get walks the table one entry per cycle through the RAM read port, keeping
// the first tag match and the oldest free entry, then writes back once.
// Release, pin and unpin do one read-modify-write of the addressed entry.
// A finished result sits in an output register, so a new request is taken
// while the previous word waits on out_stall.
module block_buffer_cache_lru_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bbc_pkg::FUNC_W-1:0]  in_func,
  input  logic [bbc_pkg::DEV_W-1:0]   in_device,
  input  logic [bbc_pkg::BLK_W-1:0]   in_block_number,
  input  logic [bbc_pkg::EIDX_W-1:0]  in_entry_index,
  input  logic [bbc_pkg::TICK_W-1:0]  in_now_tick,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bbc_pkg::EIDX_W-1:0]  out_entry_out,
  output logic                        out_hit,
  output logic                        out_needs_read,
  output logic [bbc_pkg::STAT_W-1:0]  out_status
);
  import bbc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_FIN, S_OP} state_t;

  state_t              state_r;

  // request registers
  logic [FUNC_W-1:0]   func_r;
  logic [DEV_W-1:0]    dev_r;
  logic [BLK_W-1:0]    blk_r;
  logic [EIDX_W-1:0]   eidx_r;
  logic [IDX_W-1:0]    op_idx_r;
  logic [TICK_W-1:0]   now_r;

  // scan bookkeeping
  logic [IDX_W-1:0]    scan_addr_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_pend_r;
  logic                match_found_r;
  logic [IDX_W-1:0]    match_idx_r;
  logic [CNT_W-1:0]    match_cnt_r;
  logic [TICK_W-1:0]   match_last_r;
  logic                match_dv_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [TICK_W-1:0]   free_last_r;

  // per-entry written flags
  logic [ENTRIES-1:0]  entry_vld_r;

  // output register
  logic                out_valid_r;
  logic [EIDX_W-1:0]   out_entry_r;
  logic                out_hit_r;
  logic                out_nr_r;
  logic [STAT_W-1:0]   out_status_r;

  // RAM ports
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  // combinational helpers
  logic                in_accept;
  logic                slot_free;
  logic                commit;
  logic [IDX_W-1:0]    cur_idx;
  entry_t              cur_word;
  logic                scan_hit;
  logic                scan_free;
  logic                op_in_range;
  logic [CNT_W-1:0]    op_cnt_nxt;
  logic [EIDX_W-1:0]   res_entry;
  logic                res_hit;
  logic                res_nr;
  logic [STAT_W-1:0]   res_status;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign commit    = slot_free && ((state_r == S_FIN) || (state_r == S_OP));

  // issue table reads: addressed entry when a release, pin or unpin is accepted, otherwise the scan walk
  assign ram_re    = (state_r == S_SCAN) || (in_accept && (in_func != FN_GET));
  assign ram_raddr = (state_r == S_SCAN) ? scan_addr_r : IDX_W'(in_entry_index);

  bbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entries never written read as zero
  assign cur_idx  = (state_r == S_OP) ? op_idx_r : rd_idx_r;
  assign cur_word = entry_vld_r[cur_idx] ? entry_t'(ram_rdata) : '0;

  // compare one scanned entry against the request and the best free so far
  assign scan_hit  = cur_word.tag_valid && (cur_word.device == dev_r) &&
                     (cur_word.block == blk_r);
  assign scan_free = (cur_word.ref_count == '0) &&
                     (!free_found_r || (cur_word.last_use < free_last_r));

  assign op_in_range = ({4'b0, eidx_r} < 9'(ENTRIES));
  assign op_cnt_nxt  = (func_r == FN_PIN) ? cur_word.ref_count + 1'b1
                                          : cur_word.ref_count - 1'b1;

  // form the result and the write-back word
  always_comb begin
    res_entry  = '0;
    res_hit    = 1'b0;
    res_nr     = 1'b0;
    res_status = ST_OK;
    ram_we     = 1'b0;
    ram_waddr  = op_idx_r;
    ram_wdata  = cur_word;
    if (state_r == S_FIN) begin
      if (match_found_r) begin
        res_entry = EIDX_W'(match_idx_r);
        res_hit   = 1'b1;
        ram_waddr = match_idx_r;
        ram_wdata.tag_valid  = 1'b1;
        ram_wdata.device     = dev_r;
        ram_wdata.block      = blk_r;
        ram_wdata.ref_count  = match_cnt_r + 1'b1;
        ram_wdata.last_use   = match_last_r;
        ram_wdata.data_valid = 1'b1;
        if (match_cnt_r == COUNT_MAX) begin
          res_status = ST_COUNT;
        end else begin
          res_nr = !match_dv_r;
          ram_we = commit;
        end
      end else if (free_found_r) begin
        res_entry = EIDX_W'(free_idx_r);
        res_nr    = 1'b1;
        ram_waddr = free_idx_r;
        ram_wdata.tag_valid  = 1'b1;
        ram_wdata.device     = dev_r;
        ram_wdata.block      = blk_r;
        ram_wdata.ref_count  = CNT_W'(1);
        ram_wdata.last_use   = now_r;
        ram_wdata.data_valid = 1'b1;
        ram_we = commit;
      end else begin
        res_status = ST_NOFREE;
      end
    end else if (state_r == S_OP) begin
      res_entry = eidx_r;
      ram_wdata.ref_count = op_cnt_nxt;
      if ((func_r == FN_RELEASE) && (op_cnt_nxt == '0)) begin
        ram_wdata.last_use = now_r;
      end
      if (op_in_range) begin
        if (((func_r == FN_PIN) && (cur_word.ref_count == COUNT_MAX)) ||
            ((func_r != FN_PIN) && (cur_word.ref_count == '0))) begin
          res_status = ST_COUNT;
        end else begin
          ram_we = commit;
        end
      end
    end
  end

  // sequencer, scan trackers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      entry_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == S_SCAN);
      rd_idx_r  <= scan_addr_r;

      // drop the result word once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && !commit) begin
        out_valid_r <= 1'b0;
      end

      // fold the arriving scan word into the trackers
      if (((state_r == S_SCAN) || (state_r == S_LAST)) && rd_pend_r) begin
        if (scan_hit && !match_found_r) begin
          match_found_r <= 1'b1;
          match_idx_r   <= rd_idx_r;
          match_cnt_r   <= cur_word.ref_count;
          match_last_r  <= cur_word.last_use;
          match_dv_r    <= cur_word.data_valid;
        end
        if (scan_free) begin
          free_found_r <= 1'b1;
          free_idx_r   <= rd_idx_r;
          free_last_r  <= cur_word.last_use;
        end
      end

      // mark entries written
      if (ram_we) begin
        entry_vld_r[ram_waddr] <= 1'b1;
      end

      // hand the result to the output register
      if (commit) begin
        out_valid_r  <= 1'b1;
        out_entry_r  <= res_entry;
        out_hit_r    <= res_hit;
        out_nr_r     <= res_nr;
        out_status_r <= res_status;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            func_r        <= in_func;
            dev_r         <= in_device;
            blk_r         <= in_block_number;
            eidx_r        <= in_entry_index;
            op_idx_r      <= IDX_W'(in_entry_index);
            now_r         <= in_now_tick;
            scan_addr_r   <= '0;
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            state_r       <= (in_func == FN_GET) ? S_SCAN : S_OP;
          end
        end
        S_SCAN: begin
          // advance the walk, one entry per cycle
          if (scan_addr_r == IDX_W'(ENTRIES - 1)) begin
            state_r <= S_LAST;
          end else begin
            scan_addr_r <= scan_addr_r + 1'b1;
          end
        end
        S_LAST: begin
          state_r <= S_FIN;
        end
        S_FIN, S_OP: begin
          // hold until the output register can take the word
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_entry_out  = out_entry_r;
  assign out_hit        = out_hit_r;
  assign out_needs_read = out_nr_r;
  assign out_status     = out_status_r;

endmodule

// File: rtl/bbc_checker.sv
// Port-level checker for the LRU buffer cache core, bound to the top level.
// Depends on bbc_pkg.
module bbc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bbc_pkg::EIDX_W-1:0]  out_entry_out,
  input  logic                        out_hit,
  input  logic                        out_needs_read,
  input  logic [bbc_pkg::STAT_W-1:0]  out_status
);
  import bbc_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_out) &&
      $stable(out_hit) && $stable(out_needs_read) && $stable(out_status))
    else $error("result word changed while stalled");

  // a refused get reports nothing else
  a_nofree_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOFREE) |->
      (out_entry_out == '0) && !out_hit && !out_needs_read)
    else $error("no-free result carries entry fields");

  // a disk read is only asked for by a successful get
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_needs_read |-> (out_status == ST_OK))
    else $error("needs_read with error status");

  // a hit never reports a missing free entry
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_status != ST_NOFREE))
    else $error("hit with no-free status");

  // no result word straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind block_buffer_cache_lru_core bbc_checker u_bbc_checker (.*);

// File: dv/bbc_cache_checker.sv
`timescale 1ns / 100ps
// Reply checker for the LRU buffer cache core. Keeps its own copy of the
// entry table, predicts one reply word per request and compares in order.
// Depends on bbc_pkg.
module bbc_cache_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [bbc_pkg::FUNC_W-1:0] in_func,
  input  logic [bbc_pkg::DEV_W-1:0]  in_device,
  input  logic [bbc_pkg::BLK_W-1:0]  in_block_number,
  input  logic [bbc_pkg::EIDX_W-1:0] in_entry_index,
  input  logic [bbc_pkg::TICK_W-1:0] in_now_tick,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bbc_pkg::EIDX_W-1:0] out_entry_out,
  input  logic                       out_hit,
  input  logic                       out_needs_read,
  input  logic [bbc_pkg::STAT_W-1:0] out_status,
  output int                         fail_count,
  output int                         replies_pending
);
  import bbc_pkg::*;

  typedef struct packed {
    logic [EIDX_W-1:0] entry;
    logic              hit;
    logic              needs_read;
    logic [STAT_W-1:0] status;
  } reply_t;

  // Shadow entry table
  logic              tbl_tagged [ENTRIES];
  logic [DEV_W-1:0]  tbl_device [ENTRIES];
  logic [BLK_W-1:0]  tbl_block  [ENTRIES];
  logic [CNT_W-1:0]  tbl_count  [ENTRIES];
  logic [TICK_W-1:0] tbl_stamp  [ENTRIES];
  logic              tbl_loaded [ENTRIES];

  // Reply words owed by the core, oldest first
  reply_t replies_due [$];

  // Apply one request to the shadow table and return the reply it earns
  function automatic reply_t apply_request(input logic [FUNC_W-1:0] fn,
                                           input logic [DEV_W-1:0]  dev,
                                           input logic [BLK_W-1:0]  blk,
                                           input logic [EIDX_W-1:0] idx,
                                           input logic [TICK_W-1:0] now);
    reply_t r;
    int     match;
    int     victim;
    r      = '0;
    match  = -1;
    victim = -1;
    if (fn == FN_GET) begin
      // first tagged entry holding this block wins
      for (int i = 0; i < ENTRIES; i++) begin
        if (match < 0 && tbl_tagged[i] && tbl_device[i] == dev && tbl_block[i] == blk)
          match = i;
      end
      if (match >= 0) begin
        r.entry = EIDX_W'(match);
        r.hit   = 1'b1;
        if (tbl_count[match] == COUNT_MAX) begin
          r.status = ST_COUNT;
        end else begin
          tbl_count[match]++;
          r.needs_read      = !tbl_loaded[match];
          tbl_loaded[match] = 1'b1;
        end
      end else begin
        // oldest free entry, ties to the lowest index
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_count[i] == '0 && (victim < 0 || tbl_stamp[i] < tbl_stamp[victim]))
            victim = i;
        end
        if (victim < 0) begin
          r.status = ST_NOFREE;
        end else begin
          tbl_tagged[victim] = 1'b1;
          tbl_device[victim] = dev;
          tbl_block[victim]  = blk;
          tbl_count[victim]  = CNT_W'(1);
          tbl_stamp[victim]  = now;
          tbl_loaded[victim] = 1'b1;
          r.entry            = EIDX_W'(victim);
          r.needs_read       = 1'b1;
        end
      end
    end else begin
      r.entry = idx;
      if (int'(idx) < ENTRIES) begin
        if (fn == FN_PIN) begin
          if (tbl_count[idx] == COUNT_MAX) r.status = ST_COUNT;
          else tbl_count[idx]++;
        end else if (tbl_count[idx] == '0) begin
          r.status = ST_COUNT;
        end else begin
          tbl_count[idx]--;
          // a release that frees the entry stamps its last use
          if (fn == FN_RELEASE && tbl_count[idx] == '0) tbl_stamp[idx] = now;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_tagged[i] = 1'b0;
        tbl_device[i] = '0;
        tbl_block[i]  = '0;
        tbl_count[i]  = '0;
        tbl_stamp[i]  = '0;
        tbl_loaded[i] = 1'b0;
      end
      replies_due.delete();
      fail_count = 0;
    end else begin
      // check the reply word first: it always answers an earlier request
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("reply word with nothing owed: entry_out %0d status %0d",
                 out_entry_out, out_status);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_entry_out !== want.entry) begin
            $error("entry_out: expected %0d, got %0d", want.entry, out_entry_out);
            fail_count++;
          end
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            fail_count++;
          end
          if (out_needs_read !== want.needs_read) begin
            $error("needs_read: expected %0d, got %0d", want.needs_read, out_needs_read);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(apply_request(in_func, in_device, in_block_number,
                                            in_entry_index, in_now_tick));
    end
    replies_pending <= replies_due.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Top of the LRU buffer cache testbench: clock, reset, request words and
// reply-side stall, plus the verdict. Depends on bbc_pkg,
// block_buffer_cache_lru_core and bbc_cache_checker.
module tb;
  import bbc_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int SAT_REPEAT   = 256;
  localparam int KEY_POOL     = 16;
  localparam int CALM_FROM    = 1000;
  localparam int CALM_TO      = 1200;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_LEN     = 500;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [DEV_W-1:0]  in_device;
  logic [BLK_W-1:0]  in_block_number;
  logic [EIDX_W-1:0] in_entry_index;
  logic [TICK_W-1:0] in_now_tick;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [EIDX_W-1:0] out_entry_out;
  logic              out_hit;
  logic              out_needs_read;
  logic [STAT_W-1:0] out_status;

  int                fail_count;
  int                replies_pending;
  int                items_sent = 0;
  int                rx_cycles  = 0;
  logic              calm;
  logic [TICK_W-1:0] tick;
  logic [DEV_W-1:0]  key_dev [KEY_POOL];
  logic [BLK_W-1:0]  key_blk [KEY_POOL];

  block_buffer_cache_lru_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_entry_index  (in_entry_index),
    .in_now_tick     (in_now_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_out   (out_entry_out),
    .out_hit         (out_hit),
    .out_needs_read  (out_needs_read),
    .out_status      (out_status)
  );

  bbc_cache_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_entry_index  (in_entry_index),
    .in_now_tick     (in_now_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_out   (out_entry_out),
    .out_hit         (out_hit),
    .out_needs_read  (out_needs_read),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // No idling on either side inside this window of request words
  assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

  // Reply side: random stall, one long hold-off so the core backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_cycles <= 0;
      out_stall <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles >= HOLD_AT && rx_cycles < HOLD_AT + HOLD_LEN) out_stall <= 1'b1;
      else if (calm) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 13);
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Mostly small steps forward, now and then a jump anywhere
  function automatic logic [TICK_W-1:0] advance_tick();
    if ($urandom_range(9) == 0) tick = $urandom;
    else tick = tick + TICK_W'($urandom_range(3));
    return tick;
  endfunction

  task automatic new_key(output logic [DEV_W-1:0] dev, output logic [BLK_W-1:0] blk);
    case ($urandom_range(9))
      0: begin
        dev = '0;
        blk = '1;
      end
      1: begin
        dev = '1;
        blk = '0;
      end
      default: begin
        dev = DEV_W'($urandom);
        blk = $urandom;
      end
    endcase
  endtask

  // Offer one request word and hold it until the core takes it
  task automatic issue(input logic [FUNC_W-1:0] fn, input logic [DEV_W-1:0] dev,
                       input logic [BLK_W-1:0] blk, input logic [EIDX_W-1:0] idx,
                       input logic [TICK_W-1:0] now);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= fn;
    in_device       <= dev;
    in_block_number <= blk;
    in_entry_index  <= idx;
    in_now_tick     <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    int               pick;
    int               sel;
    int               next_fill;
    logic [EIDX_W-1:0] e;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FN_GET;
    in_device       = '0;
    in_block_number = '0;
    in_entry_index  = '0;
    in_now_tick     = '0;
    tick            = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: untagged zero entries must not match, misses fill the
    // lowest oldest entry, hits, releases to zero and past it, pin and unpin
    // on an untagged entry, extremes of every field
    issue(FN_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0000_0000);
    issue(FN_GET,     8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    issue(FN_GET,     8'h00, 32'h0000_0000, 5'd7,  32'd7);
    issue(FN_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0,  32'd10);
    issue(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'd11);
    issue(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'd12);
    issue(FN_UNPIN,   8'h00, 32'h0000_0000, 5'd2,  32'd0);
    issue(FN_PIN,     8'hFF, 32'hFFFF_FFFF, 5'd2,  32'd0);
    issue(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd2,  32'd3);
    issue(FN_PIN,     8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
    issue(FN_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
    issue(FN_GET,     8'h5A, 32'h1234_5678, 5'd21, 32'd20);
    issue(FN_GET,     8'h00, 32'h0000_0000, 5'd10, 32'd21);
    issue(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd1,  32'hFFFF_FFFF);
    issue(FN_GET,     8'hFF, 32'hFFFF_FFFF, 5'd0,  32'd22);
    issue(FN_GET,     8'hA5, 32'h8000_0000, 5'd15, 32'h8000_0000);
    issue(FN_PIN,     8'hFF, 32'hFFFF_FFFF, 5'd0,  32'd23);
    issue(FN_UNPIN,   8'hFF, 32'hFFFF_FFFF, 5'd0,  32'd24);
    tick = 32'd30;

    // Drive one block to the count ceiling by gets, then one entry up by
    // pins past the ceiling and back down by releases past zero
    new_key(dev, blk);
    repeat (SAT_REPEAT) issue(FN_GET, dev, blk, EIDX_W'($urandom), advance_tick());
    e = EIDX_W'($urandom_range(ENTRIES - 1));
    repeat (SAT_REPEAT)
      issue(FN_PIN, DEV_W'($urandom), $urandom, e, advance_tick());
    repeat (SAT_REPEAT)
      issue(FN_RELEASE, DEV_W'($urandom), $urandom, e, advance_tick());

    // Random traffic over a small pool of hot blocks
    for (int k = 0; k < KEY_POOL; k++) new_key(key_dev[k], key_blk[k]);
    next_fill = items_sent + 150;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_fill) begin
        // overfill the table with new blocks, then drop one count everywhere
        repeat (ENTRIES + 2) begin
          new_key(dev, blk);
          issue(FN_GET, dev, blk, EIDX_W'($urandom), advance_tick());
        end
        for (int i = 0; i < ENTRIES; i++)
          issue(FN_RELEASE, DEV_W'($urandom), $urandom, EIDX_W'(i), advance_tick());
        next_fill = items_sent + 200;
      end
      sel = $urandom_range(99);
      if (sel < 30) begin
        if ($urandom_range(3) == 0) begin
          new_key(dev, blk);
        end else begin
          pick = $urandom_range(KEY_POOL - 1);
          dev  = key_dev[pick];
          blk  = key_blk[pick];
        end
        issue(FN_GET, dev, blk, EIDX_W'($urandom), advance_tick());
      end else if (sel < 70) begin
        issue(FN_RELEASE, DEV_W'($urandom), $urandom, EIDX_W'($urandom), advance_tick());
      end else if (sel < 85) begin
        issue(FN_UNPIN, DEV_W'($urandom), $urandom, EIDX_W'($urandom), advance_tick());
      end else begin
        issue(FN_PIN, DEV_W'($urandom), $urandom, EIDX_W'($urandom), advance_tick());
      end
      // swap a hot block now and then so old ones age out
      if ($urandom_range(49) == 0) begin
        pick = $urandom_range(KEY_POOL - 1);
        new_key(key_dev[pick], key_blk[pick]);
      end
    end
    in_valid <= 1'b0;

    // Drain the owed reply words, then watch for strays
    do @(posedge clk); while (replies_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
